/* design/bbvp_pkg.sv */
package bbvp_pkg;

	localparam int BLOCKS = 64;
	localparam int IDX_W  = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
	localparam int CNT_W  = $clog2(BLOCKS + 1);

	localparam logic [31:0] MARKER_WORD    = 32'h3872_8040;
	localparam logic [31:0] INTERVAL_RESET = 32'd1000000;

	// configuration register indexes
	localparam logic [0:0] REG_INTERVAL_LENGTH = 1'b0;
	localparam logic [0:0] REG_WAIT_FOR_MARKER = 1'b1;

	typedef struct packed {
		logic [15:0] len;
		logic [31:0] ident;
		logic [63:0] start;
	} tbl_entry_t;

	localparam int TBL_W = $bits(tbl_entry_t);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_BUMP,
		ST_TICK,
		ST_FL_SCAN,
		ST_FL_MUL,
		ST_FL_EMPTY
	} state_t;

endpackage

/* design/basic_block_vector_profiler.sv */
// load transfer: the block is ready again in the next cycle
// retired instruction: the table is searched from entry 0 upward, the first match is counted
//   (ST_BUMP), then the instruction count ticks (ST_TICK); a gated-out instruction is dropped in idle
// interval end: the table is walked up to the last touched entry (ST_FL_SCAN, ST_FL_MUL),
//   one multiply per result; an empty interval gives one marker result
// reset (arst_n low) clears control, counters, touched flags and configuration at once;
//   table contents stay undefined until loaded, so there is no clearing pass
module basic_block_vector_profiler (
	input  logic         clk,
	input  logic         arst_n,
	// configuration
	input  logic         cfg_we,
	input  logic [0:0]   cfg_addr,
	input  logic [31:0]  cfg_wdata,
	// input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [143:0] s_tdata,  // pc[63:0], insn_word[95:64], entry_id[127:96], entry_length[143:128]
	input  logic         s_tuser,  // action
	// result stream
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [95:0]  m_tdata,  // block_id[31:0], weight[95:32]
	output logic         m_tuser,  // has_block
	output logic         m_tlast
);

	import bbvp_pkg::*;

	state_t state_q, state_d;

	logic [CNT_W-1:0]  loaded_q;
	logic [31:0]       icount_q;
	logic              coll_q;
	logic [31:0]       ilen_q;
	logic              wait_q;
	logic [BLOCKS-1:0] touched_q;
	logic [CNT_W-1:0]  tcnt_q;
	logic [CNT_W-1:0]  sidx_q;
	logic              cv_q;
	logic [IDX_W-1:0]  cidx_q;
	logic [IDX_W-1:0]  hit_q;
	logic [63:0]       pc_q;
	logic              m_valid_q;
	logic [31:0]       out_id_q;
	logic [63:0]       out_weight_q;
	logic              out_has_q;
	logic              out_last_q;

	logic [63:0]       in_pc;
	logic [31:0]       in_insn;
	logic [31:0]       in_id;
	logic [15:0]       in_len;
	logic              gate_drop;
	logic              issue;
	logic              hit;
	logic              slot_free;
	logic              ic_done;
	logic [IDX_W-1:0]  widx;
	logic [31:0]       ic_next;
	logic [31:0]       cnt_old;
	logic [31:0]       cnt_new;
	logic [47:0]       prod;

	logic              tbl_we;
	tbl_entry_t        tbl_wdata;
	logic [TBL_W-1:0]  tbl_rdata;
	tbl_entry_t        tbl_rd;
	logic              cnt_we;
	logic [IDX_W-1:0]  cnt_raddr;
	logic [31:0]       cnt_rdata;

	assign in_pc   = s_tdata[63:0];
	assign in_insn = s_tdata[95:64];
	assign in_id   = s_tdata[127:96];
	assign in_len  = s_tdata[143:128];

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {out_weight_q, out_id_q};
	assign m_tuser  = out_has_q;
	assign m_tlast  = out_last_q;

	assign widx      = sidx_q[IDX_W-1:0];
	assign gate_drop = wait_q && !coll_q && (in_insn != MARKER_WORD);
	assign issue     = (sidx_q < loaded_q);
	assign tbl_rd    = tbl_entry_t'(tbl_rdata);
	assign hit       = cv_q && (tbl_rd.start == pc_q);
	assign slot_free = !m_valid_q || m_tready;
	assign ic_next   = icount_q + 32'd1;
	assign ic_done   = (ic_next == ilen_q);
	// an untouched entry reads as a zero count
	assign cnt_old   = touched_q[hit_q] ? cnt_rdata : 32'd0;
	assign cnt_new   = (&cnt_old) ? cnt_old : cnt_old + 32'd1;
	assign prod      = cnt_rdata * tbl_rd.len;

	assign tbl_we    = (state_q == ST_IDLE) && s_tvalid && !s_tuser
		&& (loaded_q < CNT_W'(BLOCKS));
	assign tbl_wdata = '{len: in_len, ident: in_id, start: in_pc};
	assign cnt_we    = (state_q == ST_BUMP);
	assign cnt_raddr = (state_q == ST_SEARCH) ? cidx_q : widx;

	bbvp_ram #(
		.WIDTH (TBL_W),
		.DEPTH (BLOCKS)
	) u_tbl_ram (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (loaded_q[IDX_W-1:0]),
		.wdata (tbl_wdata),
		.raddr (widx),
		.rdata (tbl_rdata)
	);

	bbvp_ram #(
		.WIDTH (32),
		.DEPTH (BLOCKS)
	) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (hit_q),
		.wdata (cnt_new),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid && s_tuser && !gate_drop) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (hit) begin
					state_d = ST_BUMP;
				end else if (!cv_q && !issue) begin
					state_d = ST_TICK;
				end
			end
			ST_BUMP: begin
				state_d = ST_TICK;
			end
			ST_TICK: begin
				if (ic_done) begin
					state_d = (tcnt_q == '0) ? ST_FL_EMPTY : ST_FL_SCAN;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_FL_SCAN: begin
				if (touched_q[widx] && slot_free) begin
					state_d = ST_FL_MUL;
				end
			end
			ST_FL_MUL: begin
				state_d = (tcnt_q == CNT_W'(1)) ? ST_IDLE : ST_FL_SCAN;
			end
			ST_FL_EMPTY: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q  <= '0;
			icount_q  <= '0;
			coll_q    <= 1'b0;
			ilen_q    <= INTERVAL_RESET;
			wait_q    <= 1'b0;
			touched_q <= '0;
			tcnt_q    <= '0;
			sidx_q    <= '0;
			cv_q      <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_INTERVAL_LENGTH: ilen_q <= cfg_wdata;
					REG_WAIT_FOR_MARKER: wait_q <= cfg_wdata[0];
					default: ;
				endcase
			end
			if ((state_q == ST_FL_MUL) || ((state_q == ST_FL_EMPTY) && slot_free)) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (tbl_we) begin
						loaded_q <= loaded_q + CNT_W'(1);
					end
					if (s_tvalid && s_tuser && !gate_drop) begin
						sidx_q <= '0;
						cv_q   <= 1'b0;
						if (wait_q) begin
							coll_q <= 1'b1;
						end
					end
				end
				ST_SEARCH: begin
					if (!hit) begin
						cv_q <= issue;
						if (issue) begin
							sidx_q <= sidx_q + CNT_W'(1);
						end
					end
				end
				ST_BUMP: begin
					touched_q[hit_q] <= 1'b1;
					if (!touched_q[hit_q]) begin
						tcnt_q <= tcnt_q + CNT_W'(1);
					end
				end
				ST_TICK: begin
					sidx_q   <= '0;
					icount_q <= ic_done ? 32'd0 : ic_next;
				end
				ST_FL_SCAN: begin
					if (!touched_q[widx]) begin
						sidx_q <= sidx_q + CNT_W'(1);
					end
				end
				ST_FL_MUL: begin
					touched_q[widx] <= 1'b0;
					tcnt_q          <= tcnt_q - CNT_W'(1);
					sidx_q          <= sidx_q + CNT_W'(1);
				end
				default: ;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				pc_q <= in_pc;
			end
			ST_SEARCH: begin
				cidx_q <= widx;
				if (hit) begin
					hit_q <= cidx_q;
				end
			end
			ST_FL_MUL: begin
				out_has_q    <= 1'b1;
				out_id_q     <= tbl_rd.ident;
				out_weight_q <= {16'd0, prod};
				out_last_q   <= (tcnt_q == CNT_W'(1));
			end
			ST_FL_EMPTY: begin
				if (slot_free) begin
					out_has_q    <= 1'b0;
					out_id_q     <= 32'd0;
					out_weight_q <= 64'd0;
					out_last_q   <= 1'b1;
				end
			end
			default: ;
		endcase
	end

endmodule

/* design/bbvp_ram.sv */
module bbvp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* design/bbvp_chk.sv */
module bbvp_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [95:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	// an empty-interval marker is always the last and carries zeros
	a_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast && (m_tdata == 96'd0))
		else $error("empty marker without last or with data");

	// while a non-final record waits the flush walk is still busy
	a_flush_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input ready during an unfinished interval flush");

	// after a table load the block is ready again in the next cycle
	a_load_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tuser |=> s_tready)
		else $error("not ready after a load transfer");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

endmodule

bind basic_block_vector_profiler bbvp_chk u_bbvp_chk (.*);

/* verif/tb.sv */
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bbvp_pkg::*;

	localparam bit ACT_LOAD   = 1'b0;
	localparam bit ACT_RETIRE = 1'b1;

	localparam int RANDOM_ITEMS  = 300;
	localparam int SETTLE_CYCLES = 2 * BLOCKS + 16;
	localparam int HOLD_CYCLES   = 1500;
	localparam int CYCLE_LIMIT   = 1000000;

	typedef struct packed {
		bit        has_block;
		bit [31:0] block_id;
		bit [63:0] weight;
		bit        last;
	} bbv_rec_t;

	class bbv_tracker;
		bit [63:0] start_q [BLOCKS];
		bit [31:0] ident_q [BLOCKS];
		bit [15:0] blen_q  [BLOCKS];
		bit [31:0] hits    [BLOCKS];
		bit        seen    [BLOCKS];
		int unsigned n_loaded;
		bit [31:0] icount;
		bit [31:0] ilen;
		bit        wait_mk;
		bit        gate_open;
		bbv_rec_t  pending_records[$];
		int        errors;

		function new();
			ilen = INTERVAL_RESET;
		endfunction

		function void write_reg(logic [0:0] idx, logic [31:0] val);
			if (idx == REG_INTERVAL_LENGTH)
				ilen = val;
			else
				wait_mk = val[0];
		endfunction

		function int pending();
			return pending_records.size();
		endfunction

		// one accepted input transfer; queues the records of a closing interval
		function void take_item(bit act, bit [63:0] pc, bit [31:0] insn,
				bit [31:0] id, bit [15:0] blen);
			bit found;
			int total;
			int emitted;
			bbv_rec_t r;
			if (act == ACT_LOAD) begin
				if (n_loaded < BLOCKS) begin
					start_q[n_loaded] = pc;
					ident_q[n_loaded] = id;
					blen_q[n_loaded]  = blen;
					hits[n_loaded]    = '0;
					seen[n_loaded]    = 1'b0;
					n_loaded++;
				end
				return;
			end
			if (wait_mk && !gate_open) begin
				if (insn != MARKER_WORD)
					return;
				gate_open = 1'b1;
			end
			// earliest matching entry wins on duplicate addresses
			found = 1'b0;
			for (int i = 0; i < n_loaded && !found; i++) begin
				if (start_q[i] == pc) begin
					if (hits[i] != 32'hFFFF_FFFF)
						hits[i]++;
					seen[i] = 1'b1;
					found = 1'b1;
				end
			end
			icount++;
			if (icount != ilen)
				return;
			total = 0;
			for (int i = 0; i < n_loaded; i++)
				if (seen[i])
					total++;
			emitted = 0;
			for (int i = 0; i < n_loaded; i++) begin
				if (seen[i]) begin
					r.has_block = 1'b1;
					r.block_id  = ident_q[i];
					r.weight    = {32'b0, hits[i]} * {48'b0, blen_q[i]};
					r.last      = (emitted == total - 1);
					pending_records.push_back(r);
					emitted++;
				end
				hits[i] = '0;
				seen[i] = 1'b0;
			end
			if (total == 0) begin
				r = '0;
				r.last = 1'b1;
				pending_records.push_back(r);
			end
			icount = '0;
		endfunction

		function void field_ok(string fname, bit [63:0] want, bit [63:0] got);
			if (want != got) begin
				$display("%0t: %s mismatch: expected %0h actual %0h",
					$time, fname, want, got);
				errors++;
			end
		endfunction

		function void check_record(bit hb, bit [31:0] id, bit [63:0] w, bit lst);
			bbv_rec_t e;
			if (pending_records.size() == 0) begin
				$display("%0t: extra record: expected none actual %0d %0h %0h %0d",
					$time, hb, id, w, lst);
				errors++;
				return;
			end
			e = pending_records.pop_front();
			field_ok("has_block", e.has_block, hb);
			field_ok("block_id", e.block_id, id);
			field_ok("weight", e.weight, w);
			field_ok("last", e.last, lst);
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [0:0]   cfg_addr;
	logic [31:0]  cfg_wdata;
	logic         s_tvalid;
	logic         s_tready;
	logic [143:0] s_tdata;
	logic         s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [95:0]  m_tdata;
	logic         m_tuser;
	logic         m_tlast;

	bbv_tracker trk;
	bit calm;
	bit hold_req;

	basic_block_vector_profiler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send(input bit act, input bit [63:0] pc, input bit [31:0] insn,
			input bit [31:0] id, input bit [15:0] blen);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tuser  <= act;
		s_tdata  <= {blen, id, insn, pc};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		trk.take_item(act, pc, insn, id, blen);
		@(negedge clk);
	endtask

	task automatic load(input bit [63:0] pc, input bit [31:0] id, input bit [15:0] blen);
		send(ACT_LOAD, pc, $urandom, id, blen);
	endtask

	task automatic retire(input bit [63:0] pc, input bit [31:0] insn);
		send(ACT_RETIRE, pc, insn, $urandom, 16'($urandom));
	endtask

	// drain outstanding records, then let a table walk finish
	task automatic settle();
		s_tvalid <= 1'b0;
		while (trk.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
		settle();
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		trk.write_reg(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic random_item(input int sweep, output int counted);
		bit [63:0] pc;
		int r;
		r = $urandom_range(0, 99);
		counted = 1;
		if (sweep < 0 && r < ((trk.n_loaded < BLOCKS) ? 25 : 4)) begin
			if (trk.n_loaded > 0 && $urandom_range(0, 3) == 0)
				pc = trk.start_q[$urandom_range(0, trk.n_loaded - 1)];
			else
				pc = {$urandom, $urandom};
			// loads into a full table are dropped by the block
			if (trk.n_loaded >= BLOCKS)
				counted = 0;
			load(pc, $urandom, 16'($urandom));
		end else begin
			if (sweep >= 0)
				pc = trk.start_q[sweep];
			else if (trk.n_loaded > 0 && r < 84)
				pc = trk.start_q[$urandom_range(0, trk.n_loaded - 1)];
			else
				pc = {$urandom, $urandom};
			retire(pc, ($urandom_range(0, 19) == 0) ? MARKER_WORD : 32'($urandom));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			trk.check_record(m_tuser, m_tdata[31:0], m_tdata[95:32], m_tlast);
	end

	// result side back-pressure, with one long hold-off on request
	initial begin
		bit lvl;
		int run;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				lvl = 1'b0;
				run = HOLD_CYCLES;
			end else begin
				lvl = ($urandom_range(0, 99) < 65);
				if (lvl)
					run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) :
						$urandom_range(1, 12);
				else
					run = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) :
						$urandom_range(1, 3);
			end
			m_tready <= lvl;
			repeat (run) @(negedge clk);
		end
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int n_items;
		int k;
		int nitems;
		int span;
		int counted;
		bit big;
		bit [31:0] newlen;
		trk       = new();
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_addr  = '0;
		cfg_wdata = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = ACT_LOAD;
		calm      = 1'b0;
		hold_req  = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		write_reg(REG_WAIT_FOR_MARKER, 32'd1);
		write_reg(REG_INTERVAL_LENGTH, 32'd4);
		// table with extreme fields, a duplicate address and out-of-order starts
		load(64'h0, 32'h0, 16'h0);
		load(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
		load(64'h1000, 32'h11, 16'd5);
		load(64'h1000, 32'h22, 16'd7);
		load(64'h800, 32'h33, 16'd1);
		// gated: these never count
		retire(64'h1000, 32'h13);
		retire(64'h800, ~MARKER_WORD);
		// gate lifted by clearing the enable, then closed again
		write_reg(REG_WAIT_FOR_MARKER, 32'd0);
		retire(64'h1000, 32'h0);
		retire(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		write_reg(REG_WAIT_FOR_MARKER, 32'd1);
		retire(64'h800, 32'h13);
		retire(64'h0, MARKER_WORD);
		retire(64'h800, 32'h1);
		// interval with nothing touched
		repeat (4) retire(64'h5555_0000, $urandom);
		write_reg(REG_INTERVAL_LENGTH, 32'd1);
		retire(64'h1000, $urandom);

		hold_req = 1'b1;
		n_items = 0;
		while (n_items < RANDOM_ITEMS) begin
			k = $urandom_range(0, 9);
			calm = ($urandom_range(0, 3) == 0);
			big = 1'b0;
			if (k == 1)
				write_reg(REG_WAIT_FOR_MARKER, $urandom_range(0, 1));
			if (k == 0) begin
				// lengths that cannot close an interval within this phase
				case ($urandom_range(0, 2))
					0: newlen = 32'h0;
					1: newlen = 32'hFFFF_FFFF;
					default: newlen = (trk.icount == 0) ? 32'h0 :
						$urandom_range(1, trk.icount);
				endcase
				nitems = $urandom_range(3, 8);
			end else begin
				big = (trk.n_loaded == BLOCKS && $urandom_range(0, 3) == 0);
				span = big ? $urandom_range(100, 160) : $urandom_range(1, 24);
				newlen = trk.icount + span;
				nitems = big ? span + $urandom_range(0, 8) : $urandom_range(4, 40);
			end
			write_reg(REG_INTERVAL_LENGTH, newlen);
			for (int j = 0; j < nitems; j++) begin
				random_item((big && j < trk.n_loaded) ? j : -1, counted);
				n_items += counted;
			end
		end

		settle();
		if (trk.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

/* sim.f */
design/bbvp_pkg.sv
design/bbvp_ram.sv
design/basic_block_vector_profiler.sv
design/bbvp_chk.sv
verif/tb.sv
